FILE: src/aevad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aevad_pkg
// Shared widths, constants and helpers of the adaptive energy VAD.
// ----------------------------------------------------------------------------
package aevad_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned RateW    = 31;
  localparam int unsigned HangW    = 8;
  localparam int unsigned EnergyW  = 32;
  localparam int unsigned SumW     = 48;
  localparam int unsigned MaxFrame = 4096;
  localparam int unsigned CountW   = $clog2(MaxFrame + 1);
  localparam int unsigned DivW     = SumW + 32;
  localparam int unsigned DivCntW  = $clog2(DivW);
  localparam int unsigned SqrtIter = 32;
  localparam int unsigned SqrtCntW = $clog2(SqrtIter);
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [EnergyW-1:0] Q30One = 32'h4000_0000;
  localparam logic [RateW-1:0]   RmsMax = 31'h7FFF_FFFF;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] CfgMinGrow   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxShrink = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMargin    = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHangover  = 2'd3;

  localparam logic [RateW-1:0] MinGrowRst   = 31'd1074278695;
  localparam logic [RateW-1:0] MaxShrinkRst = 31'd1073634461;
  localparam logic [RateW-1:0] MarginRst    = 31'd1181116006;
  localparam logic [HangW-1:0] HangoverRst  = 8'd1;

  // Q2.30 product back to 32 bits, saturated.
  function automatic logic [EnergyW-1:0] sat_q30(input logic [63:0] p);
    logic [EnergyW-1:0] r;
    r = (p[63:62] != 2'b00) ? '1 : p[61:30];
    return r;
  endfunction

endpackage

FILE: src/aevad_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aevad_in_if
// Sample channel: one audio sample and its end-of-frame mark per word.
// ----------------------------------------------------------------------------
interface aevad_in_if import aevad_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      last_sample;

  modport source (output valid, output sample, output last_sample, input ready);
  modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: src/aevad_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aevad_out_if
// Decision channel: one word per closed frame.
// ----------------------------------------------------------------------------
interface aevad_out_if import aevad_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               voice_active;
  logic [RateW-1:0]   frame_rms;
  logic [EnergyW-1:0] frame_threshold;

  modport source (output valid, output voice_active, output frame_rms,
                  output frame_threshold, input ready);
  modport sink   (input valid, input voice_active, input frame_rms,
                  input frame_threshold, output ready);
endinterface

FILE: src/aevad_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aevad_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module aevad_mul import aevad_pkg::*; (
  input  logic               clk_i,
  input  logic [EnergyW-1:0] a_i,
  input  logic [EnergyW-1:0] b_i,
  output logic [63:0]        p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: src/aevad_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aevad_div
// Restoring divider, one quotient bit per cycle, 80-bit dividend.
// ----------------------------------------------------------------------------
module aevad_div import aevad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivW-1:0]    dividend_i,
  input  logic [EnergyW-1:0] divisor_i,
  output logic               done_o,
  output logic [63:0]        quot_o
);

  logic               busy_q, done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [DivW-1:0]    work_q;
  logic [EnergyW-1:0] rem_q, dsr_q;
  logic [EnergyW:0]   trial;
  logic               fits;

  assign trial = {rem_q, work_q[DivW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DivCntW'(DivW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
    end else if (busy_q) begin
      work_q <= {work_q[DivW-2:0], fits};
      rem_q  <= fits ? EnergyW'(trial - {1'b0, dsr_q}) : trial[EnergyW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q[63:0];

endmodule

FILE: src/aevad_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aevad_sqrt
// Digit-by-digit integer square root of a 64-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module aevad_sqrt import aevad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [63:0]        value_i,
  output logic               done_o,
  output logic [EnergyW-1:0] root_o
);

  logic                busy_q, done_q;
  logic [SqrtCntW-1:0] cnt_q;
  logic [63:0]         v_q, res_q, bit_q, trial;
  logic                fits;

  assign trial = res_q + bit_q;
  assign fits  = v_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SqrtCntW'(SqrtIter - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (fits) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[EnergyW-1:0];

endmodule

FILE: src/adaptive_energy_vad_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_energy_vad_unit
// Energy voice activity detector with adaptive min/max threshold tracking.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word contents
//  in_i     in   sample (s16), last_sample
//  out_o    out  voice_active, frame_rms (Q15.16), frame_threshold (Q16.16)
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// A sample that does not close a frame passes through accept, square on the
// shared multiplier and accumulate. A closing sample skips the second
// division when the blend factor is zero. The bit-serial divider serves
// the mean square and the blend factor, the square root follows the mean
// square, and the multiplier steps the rest. Reset takes effect at once,
// with no clearing pass. A waiting result sits in the output register; new
// samples are still taken, and only the next frame close stalls on it.
module adaptive_energy_vad_unit import aevad_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  aevad_in_if.sink           in_i,
  aevad_out_if.source        out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [RateW-1:0]   cfg_data_i
);

  // Sequencer states.
  localparam logic [4:0] SIdle   = 5'd0;
  localparam logic [4:0] SSq     = 5'd1;
  localparam logic [4:0] SAcc    = 5'd2;
  localparam logic [4:0] SMStart = 5'd3;
  localparam logic [4:0] SMWait  = 5'd4;
  localparam logic [4:0] SRWait  = 5'd5;
  localparam logic [4:0] SUpd    = 5'd6;
  localparam logic [4:0] SMm1    = 5'd7;
  localparam logic [4:0] SMm2    = 5'd8;
  localparam logic [4:0] SFWait  = 5'd9;
  localparam logic [4:0] SB1     = 5'd10;
  localparam logic [4:0] SB2     = 5'd11;
  localparam logic [4:0] SB3     = 5'd12;
  localparam logic [4:0] ST1     = 5'd13;
  localparam logic [4:0] ST2     = 5'd14;
  localparam logic [4:0] SE1     = 5'd15;
  localparam logic [4:0] SE2     = 5'd16;
  localparam logic [4:0] SOut    = 5'd17;

  logic [4:0] state_q, state_d;

  // Configuration registers.
  logic [RateW-1:0] grow_q, shrink_q, margin_q;
  logic [HangW-1:0] hang_q;

  // Frame accumulation and tracker state.
  logic [SampleW-1:0] mag_q;
  logic               last_q;
  logic [SumW-1:0]    sum_q;
  logic [CountW-1:0]  count_q;
  logic               started_q;
  logic [EnergyW-1:0] emax_q, emin_q, maxmul_q, minmul_q;
  logic [HangW-1:0]   quiet_q;
  logic               newmax_q, newmin_q;

  // Per-frame working values.
  logic [RateW-1:0]   e_q;
  logic [RateW-1:0]   f_q;
  logic [63:0]        acc_q;
  logic [EnergyW-1:0] blend_q;
  // Decision of the frame in progress, held until the output register frees.
  logic               dec_act_q;
  logic [EnergyW-1:0] dec_thr_q;

  // Result register.
  logic               out_valid_q, act_q;
  logic [RateW-1:0]   rms_q;
  logic [EnergyW-1:0] thr_q;

  // Shared units.
  logic [EnergyW-1:0] mul_a, mul_b;
  logic [63:0]        prod;
  logic               div_start, div_done, sqrt_start, sqrt_done;
  logic [DivW-1:0]    div_dividend;
  logic [EnergyW-1:0] div_divisor, root;
  logic [63:0]        quot;

  // Combinational helpers.
  logic [EnergyW-1:0] e_ext, emax0, emin0, emax1, emin1, thr_new;
  logic               f_zero, out_free;

  aevad_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  aevad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  aevad_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (quot),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  assign in_i.ready = (state_q == SIdle);
  assign out_free   = !out_valid_q || out_o.ready;

  assign e_ext = {1'b0, e_q};
  assign emax0 = started_q ? emax_q : e_ext;
  assign emin0 = started_q ? emin_q : e_ext;
  assign emax1 = (e_ext > emax0) ? e_ext : emax0;
  assign emin1 = (e_ext < emin0) ? ((e_q == '0) ? emax1 : e_ext) : emin0;

  // Blend factor is zero for a zero maximum or a minimum at or above it.
  assign f_zero  = (emax_q == '0) || (emin_q >= emax_q);
  assign thr_new = sat_q30(prod);

  assign sqrt_start = (state_q == SMWait) && div_done;
  assign div_start  = (state_q == SMStart) || ((state_q == SMm2) && !f_zero);

  always_comb begin
    if (state_q == SMStart) begin
      div_dividend = {sum_q, 32'b0};
      div_divisor  = EnergyW'(count_q);
    end else begin
      div_dividend = DivW'({EnergyW'(emax_q - emin_q), 30'b0});
      div_divisor  = emax_q;
    end
  end

  // Operand selection for the shared multiplier; product appears next cycle.
  always_comb begin
    unique case (state_q)
      SSq: begin
        mul_a = EnergyW'(mag_q);
        mul_b = EnergyW'(mag_q);
      end
      SUpd: begin
        mul_a = maxmul_q;
        mul_b = EnergyW'(shrink_q);
      end
      SMm1: begin
        mul_a = minmul_q;
        mul_b = EnergyW'(grow_q);
      end
      SB1: begin
        mul_a = Q30One - EnergyW'(f_q);
        mul_b = emax_q;
      end
      SB2: begin
        mul_a = EnergyW'(f_q);
        mul_b = emin_q;
      end
      ST1: begin
        mul_a = blend_q;
        mul_b = EnergyW'(margin_q);
      end
      ST2: begin
        mul_a = emax_q;
        mul_b = maxmul_q;
      end
      SE1: begin
        mul_a = emin_q;
        mul_b = minmul_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:   if (in_i.valid) state_d = SSq;
      SSq:     state_d = SAcc;
      SAcc:    state_d = last_q ? SMStart : SIdle;
      SMStart: state_d = SMWait;
      SMWait:  if (div_done) state_d = SRWait;
      SRWait:  if (sqrt_done) state_d = SUpd;
      SUpd:    state_d = SMm1;
      SMm1:    state_d = SMm2;
      SMm2:    state_d = f_zero ? SB1 : SFWait;
      SFWait:  if (div_done) state_d = SB1;
      SB1:     state_d = SB2;
      SB2:     state_d = SB3;
      SB3:     state_d = ST1;
      ST1:     state_d = ST2;
      ST2:     state_d = SE1;
      SE1:     state_d = SE2;
      SE2:     state_d = SOut;
      SOut:    if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      grow_q      <= MinGrowRst;
      shrink_q    <= MaxShrinkRst;
      margin_q    <= MarginRst;
      hang_q      <= HangoverRst;
      sum_q       <= '0;
      count_q     <= '0;
      started_q   <= 1'b0;
      emax_q      <= '0;
      emin_q      <= '0;
      maxmul_q    <= Q30One;
      minmul_q    <= Q30One;
      quiet_q     <= 8'd1;
      newmax_q    <= 1'b0;
      newmin_q    <= 1'b0;
      dec_act_q   <= 1'b0;
      dec_thr_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMinGrow:   grow_q   <= cfg_data_i;
          CfgMaxShrink: shrink_q <= cfg_data_i;
          CfgMargin:    margin_q <= cfg_data_i;
          CfgHangover:  hang_q   <= cfg_data_i[HangW-1:0];
          default:      hang_q   <= hang_q;
        endcase
      end

      // A new word replaces the one leaving in the same cycle.
      if (state_q == SOut && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        SAcc: begin
          // Samples past the frame limit are dropped.
          if (count_q < CountW'(MaxFrame)) begin
            sum_q   <= sum_q + prod[SumW-1:0];
            count_q <= count_q + 1'b1;
          end
        end
        SUpd: begin
          started_q <= 1'b1;
          emax_q    <= emax1;
          emin_q    <= emin1;
          newmax_q  <= e_ext > emax0;
          newmin_q  <= e_ext < emin0;
        end
        SMm1: maxmul_q <= newmax_q ? Q30One : sat_q30(prod);
        SMm2: minmul_q <= newmin_q ? Q30One : sat_q30(prod);
        ST2: begin
          dec_thr_q <= thr_new;
          if (e_ext > thr_new) begin
            dec_act_q <= 1'b1;
            quiet_q   <= '0;
          end else if (quiet_q >= hang_q) begin
            dec_act_q <= 1'b0;
          end else begin
            dec_act_q <= 1'b1;
            quiet_q   <= quiet_q + 1'b1;
          end
        end
        SE1: emax_q <= sat_q30(prod);
        SE2: emin_q <= sat_q30(prod);
        SOut: begin
          if (out_free) begin
            sum_q   <= '0;
            count_q <= '0;
          end
        end
        default: begin
          sum_q <= sum_q;
        end
      endcase
    end
  end

  // Working registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mag_q  <= in_i.sample[SampleW-1] ? SampleW'(-in_i.sample) : in_i.sample;
      last_q <= in_i.last_sample;
    end
    if (state_q == SRWait && sqrt_done) begin
      e_q <= root[EnergyW-1] ? RmsMax : root[RateW-1:0];
    end
    if (state_q == SMm2) begin
      f_q <= '0;
    end else if (state_q == SFWait && div_done) begin
      f_q <= quot[RateW-1:0];
    end
    if (state_q == SB2) begin
      acc_q <= prod;
    end
    if (state_q == SB3) begin
      blend_q <= EnergyW'((acc_q + prod) >> 30);
    end
    if (state_q == SOut && out_free) begin
      rms_q <= e_q;
      act_q <= dec_act_q;
      thr_q <= dec_thr_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.voice_active    = act_q;
  assign out_o.frame_rms       = rms_q;
  assign out_o.frame_threshold = thr_q;

endmodule

FILE: test/tb_adaptive_energy_vad_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adaptive_energy_vad_unit
// Self-checking bench for the adaptive energy VAD. Audio words are sent
// through the sample channel, and a behavioral copy of the detector predicts
// each frame decision. Every decision word is compared field by field. The
// run covers directed extremes, register sweeps and random frames. Both
// channel sides idle at random.
// ----------------------------------------------------------------------------
module tb_adaptive_energy_vad_unit;
  import aevad_pkg::*;

  typedef struct packed {
    logic               voice_active;
    logic [RateW-1:0]   frame_rms;
    logic [EnergyW-1:0] frame_threshold;
  } decision_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RateW-1:0]   cfg_data;

  aevad_in_if  in_ch ();
  aevad_out_if out_ch ();

  adaptive_energy_vad_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow copy of the detector: registers first, then the frame state.
  logic [RateW-1:0]   grow_rate, shrink_rate, margin;
  logic [HangW-1:0]   hangover;
  logic [63:0]        sq_sum;
  int unsigned        sq_count;
  bit                 seen_frame;
  logic [EnergyW-1:0] e_max, e_min, max_mult, min_mult;
  logic [HangW-1:0]   quiet_frames;

  decision_t   pending_decisions[$];
  int unsigned fail_count;
  int unsigned words_sent;
  // When set, neither side idles; this gives a long back-to-back stretch.
  bit          calm;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("tb_adaptive_energy_vad_unit: FAIL");
    $finish;
  end

  // Q2.30 multiply with 32-bit saturation, as the detector scales its state.
  function automatic logic [EnergyW-1:0] q30_scale(logic [EnergyW-1:0] a,
                                                   logic [EnergyW-1:0] b);
    logic [63:0] p;
    p = ({32'd0, a} * {32'd0, b}) >> 30;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  // Integer square root by the digit-by-digit method.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  task automatic reset_shadow();
    grow_rate    = MinGrowRst;
    shrink_rate  = MaxShrinkRst;
    margin       = MarginRst;
    hangover     = HangoverRst;
    sq_sum       = '0;
    sq_count     = 0;
    seen_frame   = 1'b0;
    e_max        = '0;
    e_min        = '0;
    max_mult     = Q30One;
    min_mult     = Q30One;
    quiet_frames = 8'd1;
  endtask

  // Accumulates one accepted word. A closing word yields the frame decision.
  task automatic predict_word(logic signed [SampleW-1:0] s, logic last);
    logic signed [31:0] sx;
    logic [63:0]        quo, rem, mean, root, frac, blend, thr_wide;
    logic [EnergyW-1:0] energy, thr;
    decision_t          d;
    sx = 32'(s);
    if (sq_count < MaxFrame) begin
      sq_sum   = sq_sum + 64'(sx * sx);
      sq_count = sq_count + 1;
    end
    if (!last) return;

    // Mean square in Q.32 from an exact quotient and remainder.
    quo    = sq_sum / sq_count;
    rem    = sq_sum % sq_count;
    mean   = (quo << 32) + ((rem << 32) / sq_count);
    root   = int_sqrt(mean);
    energy = (root > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : root[31:0];

    if (!seen_frame) begin
      e_max      = energy;
      e_min      = energy;
      seen_frame = 1'b1;
    end
    if (energy > e_max) begin
      e_max    = energy;
      max_mult = Q30One;
    end else begin
      max_mult = q30_scale(max_mult, {1'b0, shrink_rate});
    end
    if (energy < e_min) begin
      // A silent frame must not drag the floor to zero.
      e_min    = (energy == 0) ? e_max : energy;
      min_mult = Q30One;
    end else begin
      min_mult = q30_scale(min_mult, {1'b0, grow_rate});
    end

    // Blend factor is forced to zero for an empty or inverted range.
    if (e_max == 0 || e_min >= e_max) frac = '0;
    else frac = ({32'd0, e_max - e_min} << 30) / e_max;
    blend    = ((64'(Q30One) - frac) * e_max + frac * e_min) >> 30;
    thr_wide = (blend * margin) >> 30;
    thr      = (thr_wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : thr_wide[31:0];

    if (energy > thr) begin
      d.voice_active = 1'b1;
      quiet_frames   = '0;
    end else if (quiet_frames >= hangover) begin
      d.voice_active = 1'b0;
    end else begin
      d.voice_active = 1'b1;
      quiet_frames   = quiet_frames + 8'd1;
    end

    e_max    = q30_scale(e_max, max_mult);
    e_min    = q30_scale(e_min, min_mult);
    sq_sum   = '0;
    sq_count = 0;

    d.frame_rms       = energy[RateW-1:0];
    d.frame_threshold = thr;
    pending_decisions.push_back(d);
  endtask

  // Sends one word. Valid stays high between back-to-back words and is only
  // lowered when the sender decides to idle.
  task automatic send_word(logic signed [SampleW-1:0] s, logic last);
    if (!calm && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.last_sample <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_word(s, last);
    words_sent++;
  endtask

  task automatic send_frame(int unsigned len, int unsigned amp);
    logic signed [SampleW-1:0] s;
    for (int unsigned i = 0; i < len; i++) begin
      if (amp == 0) s = '0;
      else if (amp >= 32768) s = SampleW'($urandom);
      else s = SampleW'($signed($urandom_range(2 * amp, 0)) - $signed(amp));
      send_word(s, i == len - 1);
    end
  endtask

  // Drains all decisions, then allows for a sample still being accumulated.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [RateW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CfgMinGrow:   grow_rate   = val;
      CfgMaxShrink: shrink_rate = val;
      CfgMargin:    margin      = val;
      CfgHangover:  hangover    = val[HangW-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [RateW-1:0] grow, logic [RateW-1:0] shrink,
                           logic [RateW-1:0] marg, logic [HangW-1:0] hang);
    wait_drained();
    write_reg(CfgMinGrow, grow);
    write_reg(CfgMaxShrink, shrink);
    write_reg(CfgMargin, marg);
    write_reg(CfgHangover, {23'd0, hang});
  endtask

  // Result side: ready toggles at random unless the bench is in a calm stretch.
  always @(posedge clk_i) begin
    out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
  end

  always @(posedge clk_i) begin
    decision_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_decisions.size() == 0) begin
        $error("decision word with nothing expected");
        fail_count++;
      end else begin
        want = pending_decisions.pop_front();
        if (out_ch.voice_active !== want.voice_active) begin
          $error("voice_active: expected %0d, got %0d", want.voice_active,
                 out_ch.voice_active);
          fail_count++;
        end
        if (out_ch.frame_rms !== want.frame_rms) begin
          $error("frame_rms: expected %0d, got %0d", want.frame_rms,
                 out_ch.frame_rms);
          fail_count++;
        end
        if (out_ch.frame_threshold !== want.frame_threshold) begin
          $error("frame_threshold: expected %0d, got %0d",
                 want.frame_threshold, out_ch.frame_threshold);
          fail_count++;
        end
      end
    end
  end

  // Field extremes, silent frames, one-word frames and an overlong frame.
  task automatic test_directed();
    send_word(16'sh7FFF, 1'b1);
    send_word(-16'sd32768, 1'b1);
    send_word(16'sd0, 1'b1);
    send_word(16'sd1, 1'b0);
    send_word(-16'sd1, 1'b1);
    send_frame(4, 0);
    send_frame(3, 32768);
    send_word(16'sd0, 1'b0);
    send_word(16'sh5555, 1'b0);
    send_word(-16'sh2AAB, 1'b1);
    // The pause below lets the detector drain before the long frame.
    wait_drained();
    send_frame(MaxFrame + 6, 32768);
    send_frame(2, 100);
    send_frame(1, 0);
  endtask

  // Register settings through their extremes, including out-of-range values.
  task automatic test_register_sweep();
    write_all(31'h4000_0000, 31'd0, 31'h4000_0000, 8'd0);
    repeat (6) send_frame($urandom_range(1, 6), 32768);
    send_frame(3, 0);
    write_all(31'h7FFF_FFFF, 31'h4000_0000, 31'h7FFF_FFFF, 8'd255);
    repeat (6) send_frame($urandom_range(1, 6), $urandom_range(0, 1) ? 2000 : 0);
    write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 8'hAA);
    repeat (6) send_frame($urandom_range(1, 6), 32768);
    write_all(31'h0000_0001, 31'h2AAA_AAAA, 31'h5555_5555, 8'h55);
    repeat (6) send_frame($urandom_range(1, 6), 300);
    write_all(MinGrowRst, MaxShrinkRst, MarginRst, HangoverRst);
  endtask

  // Mostly well-formed frames of random content and loudness, with a few
  // longer frames and occasional register changes between phases.
  task automatic test_random_frames();
    int unsigned amp, len, phase;
    phase = 0;
    while (words_sent < 1100 + MaxFrame) begin
      case ($urandom_range(5))
        0: amp = 0;
        1: amp = $urandom_range(1, 15);
        2: amp = $urandom_range(16, 4000);
        default: amp = 32768;
      endcase
      len = ($urandom_range(19) == 0) ? $urandom_range(20, 120)
                                      : $urandom_range(1, 10);
      // A calm stretch of back-to-back traffic on both sides.
      calm = (words_sent >= MaxFrame + 500 && words_sent < MaxFrame + 750);
      send_frame(len, amp);
      if (words_sent / 250 != phase) begin
        phase = words_sent / 250;
        calm  = 1'b0;
        write_all(RateW'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)),
                  RateW'($urandom_range(0, 32'h4000_0000)),
                  RateW'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)),
                  HangW'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 4)));
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_idx           <= CfgMinGrow;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.sample      <= '0;
    in_ch.last_sample <= 1'b0;
    fail_count = 0;
    words_sent = 0;
    calm       = 1'b0;
    reset_shadow();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_register_sweep();
    test_random_frames();

    wait_drained();
    repeat (250) @(posedge clk_i);
    if (fail_count == 0 && pending_decisions.size() == 0) begin
      $display("tb_adaptive_energy_vad_unit: PASS");
    end else begin
      $display("tb_adaptive_energy_vad_unit: FAIL");
    end
    $finish;
  end

endmodule
